// ----- hdl/lbr_pkg.sv -----
// Shared constants and helpers for the letterbox bilinear resize block.
// Used by lbr_front, lbr_back and the top level; depends on nothing.
package lbr_pkg;

    // Output image side and the fixed-point step of the source coordinate.
    localparam int OUT_SIZE  = 128;
    localparam int OUT_SHIFT = 7;            // log2(OUT_SIZE)
    localparam int FRAC_W    = OUT_SHIFT + 1; // coordinate scale D = 2 * OUT_SIZE
    localparam int WGT_W     = 2 * FRAC_W + 1;
    localparam int ACC_W     = 8 + 2 * FRAC_W;

    // Default frame store geometry.
    localparam int DEF_MAX_WIDTH  = 320;
    localparam int DEF_MAX_HEIGHT = 240;

    // Configuration register indexes.
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIX_FORMAT = 2'd2;

    localparam logic [8:0] RST_SRC_WIDTH  = 9'd320;
    localparam logic [7:0] RST_SRC_HEIGHT = 8'd240;
    localparam logic       RST_PIX_FORMAT = 1'b1;

    // Pixel formats.
    localparam logic FMT_RGB888 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    // Request kinds.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // Normalization: q = floor((|t| + 255) / 510) = floor(v / 255), v = (|t|+255) >> 1.
    // floor(v / 255) is estimated by v * ceil(2^24 / 255) >> 24, then corrected once.
    localparam int         NORM_V_W    = 23;
    localparam int         NORM_RCP_W  = 17;
    localparam logic [16:0] NORM_RCP   = 17'd65794;
    localparam int         NORM_SHIFT  = 24;
    localparam int         NORM_PROD_W = NORM_V_W + NORM_RCP_W;

    // Split a stored word into 8-bit R, G, B (R in the top byte).
    function automatic logic [23:0] expand_pixel(input logic [23:0] p, input logic fmt);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        logic [23:0] res;
        r5 = p[15:11];
        g6 = p[10:5];
        b5 = p[4:0];
        if (fmt == FMT_RGB565) begin
            res = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
        end else begin
            res = p;
        end
        return res;
    endfunction

endpackage

// ----- hdl/lbr_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module lbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 76800
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/lbr_fifo.sv -----
// Small register queue between the front and back parts.
// Standalone; no package dependency.
module lbr_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/lbr_front.sv -----
// Front part: accept requests and compute scaled source coordinates.
// Depends on lbr_pkg.
module lbr_front #(
    parameter int DIM_W = 10,
    parameter int NC_W  = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                func,
    input  logic [23:0]         pixel_value,
    input  logic [6:0]          out_col,
    input  logic [6:0]          out_row,
    input  logic [DIM_W-1:0]    eff_w,
    input  logic [DIM_W-1:0]    eff_h,
    input  logic [DIM_W-1:0]    eff_m,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [2*NC_W+24:0]  push_data
);

    logic              valid_reg;
    logic              func_reg;
    logic [23:0]       pixel_reg;
    logic [6:0]        col_reg, row_reg;
    logic [DIM_W+7:0]  span_x, span_y;
    logic [DIM_W-1:0]  gap_x, gap_y;
    logic signed [NC_W-1:0] nx, ny;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;

    // Source coordinate times D: (2c+1)*m - S*(m-w) - S.
    always_comb begin
        span_x = {col_reg, 1'b1} * eff_m;
        span_y = {row_reg, 1'b1} * eff_m;
        gap_x  = eff_m - eff_w;
        gap_y  = eff_m - eff_h;
        nx = $signed(NC_W'(span_x)) - $signed(NC_W'(gap_x) << lbr_pkg::OUT_SHIFT)
             - $signed(NC_W'(lbr_pkg::OUT_SIZE));
        ny = $signed(NC_W'(span_y)) - $signed(NC_W'(gap_y) << lbr_pkg::OUT_SHIFT)
             - $signed(NC_W'(lbr_pkg::OUT_SIZE));
    end

    assign push_data = {func_reg, pixel_reg, nx, ny};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg  <= func;
            pixel_reg <= pixel_value;
            col_reg   <= out_col;
            row_reg   <= out_row;
        end
    end

endmodule

// ----- hdl/lbr_back.sv -----
// Back part: frame store loads, bilinear fetch and accumulate, normalization.
// Depends on lbr_pkg and lbr_ram.
module lbr_back #(
    parameter int MAX_WIDTH  = lbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbr_pkg::DEF_MAX_HEIGHT,
    parameter int DIM_W      = 10,
    parameter int NC_W       = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DIM_W-1:0]   eff_w,
    input  logic [DIM_W-1:0]   eff_h,
    input  logic               pixel_format,
    input  logic               head_valid,
    input  logic [2*NC_W+24:0] head_data,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic               m_tuser
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int FW     = lbr_pkg::FRAC_W;
    localparam int ASUM_W = Y_W + DIM_W + 1;
    localparam int T_W    = lbr_pkg::ACC_W + 2;
    localparam int VW     = lbr_pkg::NORM_V_W;
    localparam int PW     = lbr_pkg::NORM_PROD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_NORM1 = 3'd4;
    localparam logic [2:0] ST_NORM2 = 3'd5;
    localparam logic [2:0] ST_NORM3 = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;

    // Queue head fields
    logic                   head_func;
    logic [23:0]            head_pixel;
    logic signed [NC_W-1:0] head_nx, head_ny;

    assign head_func  = head_data[2*NC_W+24];
    assign head_pixel = head_data[2*NC_W+23:2*NC_W];
    assign head_nx    = $signed(head_data[2*NC_W-1:NC_W]);
    assign head_ny    = $signed(head_data[NC_W-1:0]);

    // Load position
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [TOT_W-1:0] total;
    logic [POS_W-1:0] pos_eff, pos_inc;
    logic             load_fire;

    assign total     = TOT_W'(eff_w) * TOT_W'(eff_h);
    assign pos_eff   = (TOT_W'(pos_reg) >= total) ? '0 : pos_reg;
    assign pos_inc   = pos_eff + 1'b1;
    assign load_fire = (state_reg == ST_IDLE) && head_valid && (head_func == lbr_pkg::FUNC_LOAD);
    assign pos_next  = (TOT_W'(pos_inc) >= total) ? '0 : pos_inc;

    // Coordinates
    logic signed [NC_W-1:0] nx_reg, ny_reg;
    logic [X_W-1:0]         x0_reg, x1_reg;
    logic [Y_W-1:0]         y0_reg, y1_reg;
    logic [FW-1:0]          fx_reg, fy_reg;
    logic signed [NC_W-1:0] hi_x, hi_y, lim_s;
    logic [NC_W-1:0]        cmax_x, cmax_y, cx, cy;
    logic [X_W-1:0]         x0_c;
    logic [Y_W-1:0]         y0_c;
    logic                   pad_c;

    always_comb begin
        lim_s  = $signed(NC_W'(lbr_pkg::OUT_SIZE));
        hi_x   = $signed(NC_W'(eff_w) << FW) - lim_s;
        hi_y   = $signed(NC_W'(eff_h) << FW) - lim_s;
        pad_c  = (nx_reg < -lim_s) || (ny_reg < -lim_s) || (nx_reg > hi_x) || (ny_reg > hi_y);
        cmax_x = NC_W'(eff_w - 1'b1) << FW;
        cmax_y = NC_W'(eff_h - 1'b1) << FW;
        if (nx_reg < 0) begin
            cx = '0;
        end else if ($unsigned(nx_reg) > cmax_x) begin
            cx = cmax_x;
        end else begin
            cx = $unsigned(nx_reg);
        end
        if (ny_reg < 0) begin
            cy = '0;
        end else if ($unsigned(ny_reg) > cmax_y) begin
            cy = cmax_y;
        end else begin
            cy = $unsigned(ny_reg);
        end
        x0_c = X_W'(cx >> FW);
        y0_c = Y_W'(cy >> FW);
    end

    // Neighbor fetch
    logic [1:0]              k_reg;
    logic                    issue_reg;
    logic [X_W-1:0]          xs;
    logic [Y_W-1:0]          ys;
    logic [ASUM_W-1:0]       addr_sum;
    logic [FW:0]             wx, wy;
    logic [lbr_pkg::WGT_W-1:0] wgt_reg;
    logic [AW-1:0]           ram_addr;
    logic [23:0]             ram_rdata;
    logic [23:0]             chan;

    always_comb begin
        xs       = k_reg[0] ? x1_reg : x0_reg;
        ys       = k_reg[1] ? y1_reg : y0_reg;
        addr_sum = ASUM_W'(ys) * ASUM_W'(eff_w) + ASUM_W'(xs);
        wx       = k_reg[0] ? {1'b0, fx_reg} : ((FW+1)'(1) << FW) - {1'b0, fx_reg};
        wy       = k_reg[1] ? {1'b0, fy_reg} : ((FW+1)'(1) << FW) - {1'b0, fy_reg};
        ram_addr = load_fire ? pos_eff[AW-1:0] : AW'(addr_sum);
    end

    lbr_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (load_fire),
        .addr  (ram_addr),
        .wdata (head_pixel),
        .rdata (ram_rdata)
    );

    assign chan = lbr_pkg::expand_pixel(ram_rdata, pixel_format);

    // Per-channel accumulate and normalize
    logic [lbr_pkg::ACC_W-1:0] acc_reg  [3];
    logic [VW-1:0]             v_reg    [3];
    logic                      sgn_reg  [3];
    logic [PW-1:0]             prod_reg [3];
    logic [15:0]               res_reg  [3];
    logic                      pad_reg;
    logic signed [T_W-1:0]     t_c      [3];
    logic [T_W-1:0]            mag_c    [3];
    logic [15:0]               qe_c     [3];
    logic [15:0]               q_c      [3];
    logic [VW+8:0]             chk_c    [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t_c[c]   = $signed({1'b0, acc_reg[c], 1'b0})
                       - $signed(T_W'(255) << (2 * FW));
            mag_c[c] = t_c[c][T_W-1] ? $unsigned(-t_c[c]) : $unsigned(t_c[c]);
            qe_c[c]  = prod_reg[c][lbr_pkg::NORM_SHIFT +: 16];
            chk_c[c] = ((VW+9)'(qe_c[c]) << 8) - (VW+9)'(qe_c[c]);
            q_c[c]   = (chk_c[c] > (VW+9)'(v_reg[c])) ? qe_c[c] - 1'b1 : qe_c[c];
        end
    end

    // Control
    assign pop = (state_reg == ST_IDLE) && head_valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid && (head_func == lbr_pkg::FUNC_COMPUTE)) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = pad_c ? ST_DONE : ST_FETCH;
            ST_FETCH: begin
                if (k_reg == 2'd3) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_NORM1;
            ST_NORM1: state_next = ST_NORM2;
            ST_NORM2: state_next = ST_NORM3;
            ST_NORM3: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_tvalid || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            issue_reg <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            state_reg <= state_next;
            issue_reg <= (state_reg == ST_FETCH);
            if (load_fire) begin
                pos_reg <= pos_next;
            end
            if (state_reg == ST_DONE && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            nx_reg <= head_nx;
            ny_reg <= head_ny;
        end
        if (state_reg == ST_CLAMP) begin
            pad_reg <= pad_c;
            x0_reg  <= x0_c;
            y0_reg  <= y0_c;
            fx_reg  <= cx[FW-1:0];
            fy_reg  <= cy[FW-1:0];
            x1_reg  <= ((DIM_W+1)'(x0_c) + 1'b1 < (DIM_W+1)'(eff_w)) ?
                       x0_c + 1'b1 : X_W'(eff_w - 1'b1);
            y1_reg  <= ((DIM_W+1)'(y0_c) + 1'b1 < (DIM_W+1)'(eff_h)) ?
                       y0_c + 1'b1 : Y_W'(eff_h - 1'b1);
            k_reg   <= 2'd0;
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= '0;
                res_reg[c] <= '0;
            end
        end
        if (state_reg == ST_FETCH) begin
            k_reg   <= k_reg + 1'b1;
            wgt_reg <= lbr_pkg::WGT_W'(wx) * lbr_pkg::WGT_W'(wy);
        end
        for (int c = 0; c < 3; c++) begin
            if (issue_reg) begin
                acc_reg[c] <= acc_reg[c] + lbr_pkg::ACC_W'(chan[16 - 8*c +: 8])
                              * lbr_pkg::ACC_W'(wgt_reg);
            end
            if (state_reg == ST_NORM1) begin
                sgn_reg[c] <= t_c[c][T_W-1];
                v_reg[c]   <= VW'((mag_c[c] + T_W'(255)) >> 1);
            end
            if (state_reg == ST_NORM2) begin
                prod_reg[c] <= PW'(v_reg[c]) * PW'(lbr_pkg::NORM_RCP);
            end
            if (state_reg == ST_NORM3) begin
                if (sgn_reg[c]) begin
                    res_reg[c] <= -q_c[c];
                end else begin
                    res_reg[c] <= (q_c[c] > 16'd32767) ? 16'd32767 : q_c[c];
                end
            end
        end
        if (state_reg == ST_DONE && (!m_tvalid || m_tready)) begin
            m_tdata <= {res_reg[2], res_reg[1], res_reg[0]};
            m_tuser <= pad_reg;
        end
    end

endmodule

// ----- hdl/letterbox_bilinear_resize_normalize.sv -----
// Top level of the letterbox bilinear resize and normalize block.
// Depends on lbr_pkg, lbr_front, lbr_fifo, lbr_back and lbr_ram.
//
// Stream in requests on s_*: tuser 0 loads the next source pixel into the frame
// store in raster order, tuser 1 asks for one pixel of the square 128x128 letterbox
// output and yields one result on m_* (three Q1.15 channels, tuser set for padding).
// The back part stores a load while it is idle; an output pixel passes through
// a dequeue step, a clamp step, four frame store reads through the single RAM
// port, a drain step, three normalize steps and a hand-off step. A padding
// pixel skips the reads and normalization. The front part and a four-deep queue
// accept new requests while the back part works. Write the size and format
// registers only while the block is idle; the load address wraps after
// width*height pixels and restarts at zero when the size shrinks below it.
module letterbox_bilinear_resize_normalize #(
    parameter int MAX_WIDTH  = lbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbr_pkg::DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_value[23:0], out_col[30:24], out_row[37:31]
    input  logic        s_tuser,   // func
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_norm[15:0], green_norm[31:16], blue_norm[47:32]
    output logic        m_tuser,   // in_padding
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wr_data
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int NC_W    = DIM_W + 10;
    localparam int ENT_W   = 2 * NC_W + 25;

    // Configuration registers
    logic [8:0] src_width_reg;
    logic [7:0] src_height_reg;
    logic       pix_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= lbr_pkg::RST_SRC_WIDTH;
            src_height_reg <= lbr_pkg::RST_SRC_HEIGHT;
            pix_format_reg <= lbr_pkg::RST_PIX_FORMAT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lbr_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_wr_data;
                lbr_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_wr_data[7:0];
                lbr_pkg::REG_PIX_FORMAT: pix_format_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, oversize saturates at the store maximum.
    logic [DIM_W-1:0] eff_w, eff_h, eff_m;

    always_comb begin
        if (src_width_reg == '0) begin
            eff_w = DIM_W'(1);
        end else if (32'(src_width_reg) > MAX_WIDTH) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = DIM_W'(src_width_reg);
        end
        if (src_height_reg == '0) begin
            eff_h = DIM_W'(1);
        end else if (32'(src_height_reg) > MAX_HEIGHT) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = DIM_W'(src_height_reg);
        end
        eff_m = (eff_w > eff_h) ? eff_w : eff_h;
    end

    // Front part: take the request, compute scaled coordinates
    logic             push_valid, push_ready;
    logic [ENT_W-1:0] push_data;

    lbr_front #(
        .DIM_W (DIM_W),
        .NC_W  (NC_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tuser),
        .pixel_value (s_tdata[23:0]),
        .out_col     (s_tdata[30:24]),
        .out_row     (s_tdata[37:31]),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .eff_m       (eff_m),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // Hold requests between the two parts
    logic             head_valid, pop;
    logic [ENT_W-1:0] head_data;

    lbr_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (4)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_data   (head_data)
    );

    // Back part: store loads, interpolate, normalize, drive the result register
    lbr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIM_W      (DIM_W),
        .NC_W       (NC_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .pixel_format (pix_format_reg),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ----- tb/testbench.sv -----
// Stream testbench for the letterbox bilinear resize and normalize block.
// Loads small frames, requests output pixels, and checks each result against
// an in-bench predictor of the resize math. Depends on lbr_pkg and the RTL top.
module testbench;

    typedef struct packed {
        logic        func;
        logic [23:0] pixel_value;
        logic [6:0]  out_col;
        logic [6:0]  out_row;
    } request_t;

    typedef struct packed {
        logic [15:0] red_norm;
        logic [15:0] green_norm;
        logic [15:0] blue_norm;
        logic        in_padding;
    } pixel_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_wr_data = '0;

    letterbox_bilinear_resize_normalize u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: its own copy of the store and registers.
    logic [23:0] pix_mem [0:76799];
    int unsigned load_addr = 0;
    logic [8:0]  cur_width = lbr_pkg::RST_SRC_WIDTH;
    logic [7:0]  cur_height = lbr_pkg::RST_SRC_HEIGHT;
    logic        cur_format = lbr_pkg::RST_PIX_FORMAT;

    request_t   pending_reqs[$];
    pixel_out_t expected_pixels[$];
    int         fail_count = 0;
    bit         quiet_phase = 0;    // no idling near the end
    bit         hold_sink = 0;      // long receiver hold-off request

    function automatic logic [15:0] to_q15(longint a);
        longint dd, n, d, q;
        dd = 256 * 256;
        n = 32768 * (2 * a - 255 * dd);
        d = 255 * dd;
        if (n >= 0) q = (2 * n + d) / (2 * d);
        else q = -((-2 * n + d) / (2 * d));
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic logic [23:0] fetch_rgb(longint w, longint x, longint y);
        longint a;
        logic [23:0] p;
        a = y * w + x;
        if (a < 0 || a >= 76800) a = 0;
        p = pix_mem[a];
        if (cur_format == lbr_pkg::FMT_RGB565)
            return {p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
        return p;
    endfunction

    // Apply one request to the predictor; record a result for compute requests.
    task automatic predict_resize(request_t r);
        longint w, h, m, nx, ny, x0, y0, x1, y1, fx, fy, acc;
        logic [23:0] c00, c10, c01, c11;
        pixel_out_t res;
        int unsigned total;
        w = (cur_width == 0) ? 1 : (cur_width > 320 ? 320 : cur_width);
        h = (cur_height == 0) ? 1 : (cur_height > 240 ? 240 : cur_height);
        if (r.func == lbr_pkg::FUNC_LOAD) begin
            total = 32'(w * h);
            if (load_addr >= total) load_addr = 0;
            pix_mem[load_addr] = r.pixel_value;
            load_addr++;
            if (load_addr >= total) load_addr = 0;
            return;
        end
        m = (w > h) ? w : h;
        nx = (2 * longint'(r.out_col) + 1) * m - 128 * (m - w) - 128;
        ny = (2 * longint'(r.out_row) + 1) * m - 128 * (m - h) - 128;
        res = '0;
        if (nx < -128 || ny < -128 || nx > 256 * w - 128 || ny > 256 * h - 128) begin
            res.in_padding = 1'b1;
        end else begin
            if (nx < 0) nx = 0;
            if (nx > 256 * (w - 1)) nx = 256 * (w - 1);
            if (ny < 0) ny = 0;
            if (ny > 256 * (h - 1)) ny = 256 * (h - 1);
            x0 = nx / 256; fx = nx % 256;
            y0 = ny / 256; fy = ny % 256;
            x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
            c00 = fetch_rgb(w, x0, y0);
            c10 = fetch_rgb(w, x1, y0);
            c01 = fetch_rgb(w, x0, y1);
            c11 = fetch_rgb(w, x1, y1);
            for (int k = 0; k < 3; k++) begin
                acc = c00[23-8*k -: 8] * (256 - fx) * (256 - fy)
                    + c10[23-8*k -: 8] * fx * (256 - fy)
                    + c01[23-8*k -: 8] * (256 - fx) * fy
                    + c11[23-8*k -: 8] * fx * fy;
                if (k == 0) res.red_norm = to_q15(acc);
                else if (k == 1) res.green_norm = to_q15(acc);
                else res.blue_norm = to_q15(acc);
            end
        end
        expected_pixels.insert(expected_pixels.size(), res);
    endtask

    // Driver: offer queued requests, idle in random bursts.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_resize(request_t'({s_tuser, s_tdata[23:0], s_tdata[30:24],
                                           s_tdata[37:31]}));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                if (s_tvalid && s_tready) s_tvalid <= 1'b0;
            end else if (!s_tvalid || s_tready) begin
                if (!quiet_phase && !hold_sink && $urandom_range(0, 15) == 0) begin
                    src_gap <= $urandom_range(1, 17);
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.func;
                    s_tdata <= {2'b00, r.out_row, r.out_col, r.pixel_value};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare accepted results; receiver stalls in bursts.
    int sink_gap = 0;
    always @(posedge aclk) begin
        pixel_out_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 12) == 0) begin
                sink_gap <= $urandom_range(1, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hold off the receiver for a long stretch when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                repeat (400) @(posedge aclk);
                hold_sink <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);    // loads cause no result; let them drain
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lbr_pkg::REG_SRC_WIDTH) cur_width = val;
        else if (idx == lbr_pkg::REG_SRC_HEIGHT) cur_height = val[7:0];
        else if (idx == lbr_pkg::REG_PIX_FORMAT) cur_format = val[0];
    endtask

    task automatic queue_req(logic func, logic [23:0] pv, logic [6:0] c, logic [6:0] r);
        request_t q;
        q.func = func; q.pixel_value = pv; q.out_col = c; q.out_row = r;
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    // Queue n load requests with random pixels.
    task automatic queue_frame(int n);
        for (int i = 0; i < n; i++)
            queue_req(lbr_pkg::FUNC_LOAD, 24'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // One phase: set geometry, load up to the end of a frame, then request pixels.
    task automatic run_phase(logic [8:0] w, logic [7:0] h, logic fmt, int n_out);
        wait_idle();
        write_reg(lbr_pkg::REG_SRC_WIDTH, w);
        write_reg(lbr_pkg::REG_SRC_HEIGHT, {1'b0, h});
        write_reg(lbr_pkg::REG_PIX_FORMAT, {8'd0, fmt});
        // realign the load address: finish the frame it is in
        begin
            int total;
            int ew, eh;
            ew = (w == 0) ? 1 : (w > 320 ? 320 : w);
            eh = (h == 0) ? 1 : (h > 240 ? 240 : h);
            total = ew * eh;
            queue_frame((load_addr >= total) ? total : total - load_addr);
        end
        for (int i = 0; i < n_out; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_req(lbr_pkg::FUNC_COMPUTE, 24'($urandom), 7'($urandom), 7'($urandom));
            else
                queue_req(lbr_pkg::FUNC_COMPUTE, 24'($urandom), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: extremes, both formats, degenerate sizes, index corners.
        run_phase(9'd2, 8'd2, lbr_pkg::FMT_RGB888, 0);
        wait_idle();
        pending_reqs.delete();
        for (int i = 0; i < 4; i++)
            queue_req(lbr_pkg::FUNC_LOAD, (i[0]) ? 24'hFFFFFF : 24'h000000, 7'd0, 7'd0);
        queue_req(lbr_pkg::FUNC_COMPUTE, 24'd0, 7'd0, 7'd0);
        queue_req(lbr_pkg::FUNC_COMPUTE, 24'd0, 7'd127, 7'd127);
        queue_req(lbr_pkg::FUNC_COMPUTE, 24'd0, 7'd64, 7'd0);
        queue_req(lbr_pkg::FUNC_COMPUTE, 24'd0, 7'd0, 7'd127);
        run_phase(9'd0, 8'd0, lbr_pkg::FMT_RGB565, 3);     // zero sizes act as one
        run_phase(9'd3, 8'd1, lbr_pkg::FMT_RGB565, 4);     // wide: vertical padding
        run_phase(9'd1, 8'd5, lbr_pkg::FMT_RGB888, 4);     // tall: horizontal padding
        run_phase(9'd511, 8'd1, lbr_pkg::FMT_RGB888, 2);   // width saturates at max
        // Shrink the size to 2x1, then load two pixels from address zero.
        wait_idle();
        write_reg(lbr_pkg::REG_SRC_WIDTH, 9'd2);
        write_reg(lbr_pkg::REG_SRC_HEIGHT, 9'd1);
        queue_req(lbr_pkg::FUNC_LOAD, 24'h00FFFF, 7'd0, 7'd0);
        queue_req(lbr_pkg::FUNC_LOAD, 24'hFF0000, 7'd0, 7'd0);
        queue_req(lbr_pkg::FUNC_COMPUTE, 24'd0, 7'd10, 7'd64);
        // Long receiver hold-off while requests keep coming.
        wait_idle();
        hold_sink = 1;
        run_phase(9'd4, 8'd3, lbr_pkg::FMT_RGB565, 40);
        // Sender pause until everything has drained, then random phases.
        for (int p = 0; p < 8; p++) begin
            int w, h;
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
            if (p == 7) quiet_phase = 1;
            run_phase(9'(w), 8'(h), 1'($urandom_range(0, 1)), 25);
        end
        wait_idle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
